// ===== src/prq_pkg.sv =====
// Shared types and constants of the priority ready queue.
package prq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam int ID_BITS             = 16;
   localparam int PRIORITY_BITS       = 8;
   localparam int COUNT_BITS          = 5;

   // Operation carried by one request.
   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_POP    = 1'b1
   } op_type;

   // Ordering mode held in the one control register.
   typedef enum logic {
      MODE_SORTED = 1'b0,
      MODE_FIFO   = 1'b1
   } mode_type;

   typedef struct packed {
      op_type                   op;
      logic [ID_BITS-1:0]       entry_id;
      logic [PRIORITY_BITS-1:0] entry_priority;
   } req_type;

   typedef struct packed {
      logic                     popped_valid;
      logic [ID_BITS-1:0]       popped_id;
      logic [PRIORITY_BITS-1:0] popped_priority;
      logic                     head_valid;
      logic [ID_BITS-1:0]       head_id;
      logic [PRIORITY_BITS-1:0] head_priority;
      logic [COUNT_BITS-1:0]    entry_count;
      logic                     insert_dropped;
   } rsp_type;

   // One stored queue entry.
   typedef struct packed {
      logic [ID_BITS-1:0]       id;
      logic [PRIORITY_BITS-1:0] prio;
   } slot_type;

   // Control broadcast from the top level to every cell.
   typedef struct packed {
      logic     insert;
      logic     pop;
      mode_type mode;
      slot_type new_slot;
   } cell_ctrl_type;

endpackage

// ===== src/prq_cell.sv =====
// One slot of the queue: holds an entry and shifts with its neighbors.
module prq_cell import prq_pkg::*; (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic          occupied,
   input  logic          ahead_in,
   input  slot_type      left_slot,
   input  slot_type      right_slot,
   output logic          ahead_out,
   output slot_type      cur_slot,
   output slot_type      next_slot
);

   slot_type slot_ff;
   slot_type slot_in;
   logic     key_ahead;
   logic     stays_here;

   // The held entry stays in front when its key is not greater than the new one.
   always_comb begin
      if (slot_ff.prio != ctrl.new_slot.prio) begin
         key_ahead = slot_ff.prio < ctrl.new_slot.prio;
      end else begin
         key_ahead = slot_ff.id <= ctrl.new_slot.id;
      end
   end

   assign stays_here = occupied && ((ctrl.mode == MODE_FIFO) || key_ahead);
   assign ahead_out  = ahead_in && stays_here;

   always_comb begin
      slot_in = slot_ff;
      if (ctrl.pop) begin
         slot_in = right_slot;
      end else if (ctrl.insert) begin
         if (ahead_out) begin
            slot_in = slot_ff;
         end else if (ahead_in) begin
            slot_in = ctrl.new_slot;
         end else begin
            slot_in = left_slot;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign cur_slot  = slot_ff;
   assign next_slot = slot_in;

endmodule

// ===== src/priority_ready_queue_top.sv =====
// Top level of the priority ready queue: a shifting chain of entry cells.
//
// The queue holds up to QUEUE_DEPTH task entries in a row of cells, cell 0
// being the head. Each request either inserts an entry or pops the head,
// and every request yields exactly one response carrying the popped entry,
// the head after the request, the entry count and a drop flag. In sorted
// mode a new entry goes in front of the first held entry whose key
// (priority, then id) is strictly greater than its own; in FIFO mode it
// goes to the tail. An insert into a full queue is dropped and flagged,
// and a pop of an empty queue reports no popped entry. Every cell compares
// its entry with the new one in the same cycle and takes its own, the new
// or its neighbor's entry, so one request is processed per clock while
// req_stall is low; its response goes to the output register, else the skid
// entry. A two-entry response buffer lets one more request transfer
// while a response is stalled; req_stall rises only when both are full.
// Stored entries have no reset; only slots below the count are ever read.
// The order mode register takes a write in any cycle (csr_ready is always
// high) and must be written only while no request is in flight.
module priority_ready_queue_top import prq_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_data
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   mode_type      mode_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;

   logic          out_valid_ff;
   rsp_type       out_ff;
   logic          skid_valid_ff;
   rsp_type       skid_ff;

   logic          req_accept;
   logic          rsp_take;
   logic          queue_full;
   logic          queue_empty;
   cell_ctrl_type ctrl;
   rsp_type       rsp_new;

   logic     [QUEUE_DEPTH:0]   ahead_chain;
   logic     [QUEUE_DEPTH-1:0] occupied;
   slot_type                   cur_slots  [QUEUE_DEPTH];
   slot_type                   next_slots [QUEUE_DEPTH];

   // The order mode register; the port has no back-pressure.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SORTED;
      end else if (csr_valid && csr_ready) begin
         mode_ff <= mode_type'(csr_data);
      end
   end

   // Handshakes. A request transfers whenever the skid entry is free.
   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = out_valid_ff;
   assign rsp_data   = out_ff;
   assign rsp_take   = out_valid_ff && !rsp_stall;

   assign queue_full  = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign queue_empty = (cnt_ff == '0);

   // Control broadcast to the cells for this cycle.
   always_comb begin
      ctrl.insert        = req_accept && (req_data.op == OP_INSERT) && !queue_full;
      ctrl.pop           = req_accept && (req_data.op == OP_POP) && !queue_empty;
      ctrl.mode          = mode_ff;
      ctrl.new_slot.id   = req_data.entry_id;
      ctrl.new_slot.prio = req_data.entry_priority;
   end

   // The chain of cells. Each cell learns from its left neighbor whether
   // every entry in front of it stays ahead of the new entry.
   assign ahead_chain[0] = 1'b1;

   for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
      slot_type left_slot;
      slot_type right_slot;

      assign occupied[k] = (CNT_W'(k) < cnt_ff);

      if (k == 0) begin : g_first
         assign left_slot = ctrl.new_slot;
      end else begin : g_mid
         assign left_slot = cur_slots[k-1];
      end

      if (k == QUEUE_DEPTH - 1) begin : g_last
         assign right_slot = cur_slots[k];
      end else begin : g_inner
         assign right_slot = cur_slots[k+1];
      end

      prq_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupied   (occupied[k]),
         .ahead_in   (ahead_chain[k]),
         .left_slot  (left_slot),
         .right_slot (right_slot),
         .ahead_out  (ahead_chain[k+1]),
         .cur_slot   (cur_slots[k]),
         .next_slot  (next_slots[k])
      );
   end

   // Entry count.
   always_comb begin
      cnt_in = cnt_ff;
      if (ctrl.insert) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (ctrl.pop) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // Response of the request that transfers in this cycle.
   always_comb begin
      rsp_new                 = '0;
      rsp_new.popped_valid    = ctrl.pop;
      rsp_new.insert_dropped  = req_data.op == OP_INSERT && queue_full;
      rsp_new.entry_count     = COUNT_BITS'(cnt_in);
      if (ctrl.pop) begin
         rsp_new.popped_id       = cur_slots[0].id;
         rsp_new.popped_priority = cur_slots[0].prio;
      end
      if (cnt_in != '0) begin
         rsp_new.head_valid    = 1'b1;
         rsp_new.head_id       = next_slots[0].id;
         rsp_new.head_priority = next_slots[0].prio;
      end
   end

   // Output register with one skid entry behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_take) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= req_accept;
         end
      end else if (req_accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_take) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (req_accept) begin
            out_ff <= rsp_new;
         end
      end else if (req_accept) begin
         skid_ff <= rsp_new;
      end
   end

endmodule
